// ===== rtl/positional_list_insert_delete_core_assert.svh =====
// Assertion macros shared by the list checker.
`ifndef POSITIONAL_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PL_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PL_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ===== rtl/pl_pkg.sv =====
// Package with types and constants of the positional list core.
`default_nettype none
package pl_pkg;
    localparam int LIST_DEPTH = 16;
    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int MODE_W = 3;
    localparam int POS_W = 5;
    localparam int STAT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TAIL_INS = 3'd0,
        MODE_FRONT_INS = 3'd1,
        MODE_POS_INS = 3'd2,
        MODE_REM_FRONT = 3'd3,
        MODE_REM_TAIL = 3'd4,
        MODE_REM_VALUE = 3'd5,
        MODE_CLEAR = 3'd6,
        MODE_DUMP = 3'd7
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK = 2'd0,
        ST_FULL = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPACT,
        S_DUMP,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the request fields
        logic insert;    // shift up and write at the insert position
        logic rem_front; // shift all entries down by one
        logic rem_tail;  // drop the last entry
        logic clear;     // drop all entries
        logic cmp_step;  // one compaction step of remove by value
        logic cmp_start; // start compaction scan
        logic dump_start;
        logic dump_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic range_bad;
        logic cmp_done;
        logic dump_last;
    } t_stat;
endpackage
`default_nettype wire

// ===== rtl/pl_if.sv =====
// Valid/ready request and result channel interfaces for the list core.
`default_nettype none
interface pl_in_if;
    logic valid;
    logic ready;
    logic [2:0] mode;
    logic signed [31:0] value;
    logic [4:0] position;
    modport source (output valid, mode, value, position, input ready);
    modport sink (input valid, mode, value, position, output ready);
endinterface

interface pl_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] element;
    logic [4:0] count;
    logic [1:0] status;
    logic last;
    modport source (output valid, element, count, status, last, input ready);
    modport sink (input valid, element, count, status, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/pl_datapath.sv =====
// Datapath of the list core: shift cells, count, compaction and dump pointers.
`default_nettype none
module pl_datapath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire pl_pkg::t_cmd           i_cmd,
    input  wire logic [2:0]             i_mode,
    input  wire logic [31:0]            i_value,
    input  wire logic [4:0]             i_position,
    output pl_pkg::t_stat               o_stat,
    output logic [31:0]                 o_dump_word,
    output logic [pl_pkg::CNT_W-1:0]    o_count
);
    import pl_pkg::*;

    logic [WORD_W-1:0] r_cell [LIST_DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [WORD_W-1:0] r_value;
    logic [POS_W-1:0]  r_pos;
    logic [2:0]        r_mode;
    logic [CNT_W-1:0]  r_rd, r_wr;
    logic [CNT_W-1:0]  ins_pos;
    logic [CNT_W-1:0]  pos_ext;
    logic [IDX_W-1:0]  rd_idx, wr_idx;

    assign rd_idx = r_rd[IDX_W-1:0];
    assign wr_idx = r_wr[IDX_W-1:0];

    // Zero-extend or truncate the requested position to the count width.
    always_comb begin
        pos_ext = '0;
        if (CNT_W >= POS_W) pos_ext = CNT_W'(r_pos);
        else if (r_pos > POS_W'(LIST_DEPTH)) pos_ext = CNT_W'(LIST_DEPTH) + CNT_W'(1);
        else pos_ext = CNT_W'(r_pos);
    end

    // Insert position by mode.
    always_comb begin
        case (t_mode'(r_mode))
            MODE_TAIL_INS:  ins_pos = r_count;
            MODE_FRONT_INS: ins_pos = '0;
            default:        ins_pos = pos_ext;
        endcase
    end

    // Latched request fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_pos <= i_position;
            r_mode <= i_mode;
        end
    end

    // Shift cells take a lower or upper neighbor, the new word or a kept word.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (i_cmd.insert) begin
                if (CNT_W'(k) == ins_pos) r_cell[k] <= r_value;
                else if (CNT_W'(k) > ins_pos && k > 0) r_cell[k] <= r_cell[(k > 0) ? k-1 : 0];
            end else if (i_cmd.rem_front) begin
                if (k < LIST_DEPTH - 1) r_cell[k] <= r_cell[(k < LIST_DEPTH-1) ? k+1 : k];
            end
        end
        if (i_cmd.cmp_step && r_rd < r_count && r_cell[rd_idx] != r_value)
            r_cell[wr_idx] <= r_cell[rd_idx];
    end

    // Scan pointers for compaction and dump.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else if (i_cmd.cmp_start || i_cmd.dump_start) begin
            r_rd <= '0;
            r_wr <= '0;
        end else if (i_cmd.cmp_step) begin
            if (r_rd < r_count) begin
                r_rd <= r_rd + CNT_W'(1);
                if (r_cell[rd_idx] != r_value) r_wr <= r_wr + CNT_W'(1);
            end
        end else if (i_cmd.dump_step) begin
            r_rd <= r_rd + CNT_W'(1);
        end
    end

    // Entry count.
    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) n_count = r_count + CNT_W'(1);
        else if (i_cmd.rem_front || i_cmd.rem_tail) n_count = r_count - CNT_W'(1);
        else if (i_cmd.clear) n_count = '0;
        else if (i_cmd.cmp_step && r_rd >= r_count) n_count = r_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else r_count <= n_count;
    end

    assign o_stat.full = (r_count >= CNT_W'(LIST_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.range_bad = ({1'b0, pos_ext} > {1'b0, r_count}) || (32'(r_pos) > 32'(LIST_DEPTH));
    assign o_stat.cmp_done = (r_rd >= r_count);
    assign o_stat.dump_last = (r_rd + CNT_W'(1) >= r_count);
    assign o_dump_word = r_cell[rd_idx];
    assign o_count = r_count;
endmodule
`default_nettype wire

// ===== rtl/pl_control.sv =====
// Controller of the list core: sequences operations and drives the result register.
`default_nettype none
module pl_control (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    pl_in_if.sink                     i_req,
    pl_out_if.source                  o_res,
    input  wire pl_pkg::t_stat        i_stat,
    input  wire logic [31:0]          i_dump_word,
    input  wire logic [pl_pkg::CNT_W-1:0] i_count,
    output pl_pkg::t_cmd              o_cmd
);
    import pl_pkg::*;

    t_state r_state, n_state;
    logic r_ovalid, n_ovalid;
    logic [WORD_W-1:0] r_elem, n_elem;
    logic [STAT_W-1:0] r_status, n_status;
    logic r_last, n_last;
    logic [4:0] r_cnt, n_cnt;
    logic r_pend, n_pend;
    logic [STAT_W-1:0] r_pst, n_pst;
    logic [2:0] r_mode;
    logic out_free;
    logic acc;

    assign out_free = !r_ovalid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && !r_pend;
    assign acc = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (acc) r_mode <= i_req.mode;
    end

    // State register and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_pend <= n_pend;
        end
        r_elem <= n_elem;
        r_status <= n_status;
        r_last <= n_last;
        r_cnt <= n_cnt;
        r_pst <= n_pst;
    end

    // Next state, commands and result.
    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && !o_res.ready;
        n_elem = r_elem;
        n_status = r_status;
        n_last = r_last;
        n_cnt = r_cnt;
        n_pend = r_pend;
        n_pst = r_pst;
        o_cmd = '0;
        o_cmd.load = acc;
        // A single-result operation finishes by posting its pending result.
        if (r_pend && out_free) begin
            n_ovalid = 1'b1;
            n_elem = '0;
            n_status = r_pst;
            n_last = 1'b1;
            n_cnt = 5'(i_count);
            n_pend = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (acc) n_state = S_RESULT;
            end
            S_RESULT: begin
                n_state = S_IDLE;
                n_pend = 1'b1;
                n_pst = ST_OK;
                case (t_mode'(r_mode))
                    MODE_TAIL_INS, MODE_FRONT_INS, MODE_POS_INS: begin
                        if (i_stat.full) n_pst = ST_FULL;
                        else if (t_mode'(r_mode) == MODE_POS_INS && i_stat.range_bad)
                            n_pst = ST_RANGE;
                        else o_cmd.insert = 1'b1;
                    end
                    MODE_REM_FRONT: begin
                        if (i_stat.empty) n_pst = ST_EMPTY;
                        else o_cmd.rem_front = 1'b1;
                    end
                    MODE_REM_TAIL: begin
                        if (i_stat.empty) n_pst = ST_EMPTY;
                        else o_cmd.rem_tail = 1'b1;
                    end
                    MODE_REM_VALUE: begin
                        if (i_stat.empty) n_pst = ST_EMPTY;
                        else begin
                            o_cmd.cmp_start = 1'b1;
                            n_pend = 1'b0;
                            n_state = S_COMPACT;
                        end
                    end
                    MODE_CLEAR: o_cmd.clear = 1'b1;
                    default: begin
                        o_cmd.dump_start = 1'b1;
                        n_pend = 1'b0;
                        n_state = S_DUMP;
                    end
                endcase
            end
            S_COMPACT: begin
                o_cmd.cmp_step = 1'b1;
                if (i_stat.cmp_done) begin
                    n_pend = 1'b1;
                    n_pst = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                // Dump: one result per entry while the output register is free.
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_status = ST_OK;
                    n_elem = i_stat.empty ? '0 : i_dump_word;
                    n_last = i_stat.empty || i_stat.dump_last;
                    n_cnt = 5'(i_count);
                    o_cmd.dump_step = 1'b1;
                    if (n_last) n_state = S_IDLE;
                end
            end
        endcase
    end

    assign o_res.valid = r_ovalid;
    assign o_res.element = r_elem;
    assign o_res.count = r_cnt;
    assign o_res.status = r_status;
    assign o_res.last = r_last;
endmodule
`default_nettype wire

// ===== rtl/positional_list_insert_delete_core.sv =====
// Top level of the positional list core.
// Fixed-capacity ordered list of 32-bit signed words. Inserts, front/tail
// removal and clear latch the request, then shift cells or set the count
// at once; remove by value latches and scans one entry a cycle; dump gives
// one result a cycle while the result output is not stalled (one result
// for an empty list). A request is taken only after the previous one has
// finished; the result register frees the controller once its last result
// is posted, and a stalled result output holds the next request's result
// back. Count in a result is the count after the operation.
`default_nettype none
module positional_list_insert_delete_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pl_in_if.sink     i_req,
    pl_out_if.source  o_res
);
    import pl_pkg::*;

    t_cmd cmd;
    t_stat stat;
    logic [WORD_W-1:0] dump_word;
    logic [CNT_W-1:0] count;

    pl_control u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .o_res(o_res),
        .i_stat(stat), .i_dump_word(dump_word), .i_count(count), .o_cmd(cmd)
    );

    pl_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_mode(i_req.mode), .i_value(i_req.value), .i_position(i_req.position),
        .o_stat(stat), .o_dump_word(dump_word), .o_count(count)
    );
endmodule
`default_nettype wire

// ===== rtl/pl_checker.sv =====
// Port-level checker of the list core and its bind.
`default_nettype none
`include "positional_list_insert_delete_core_assert.svh"
module pl_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [4:0] out_count,
    input wire logic [1:0] out_status,
    input wire logic out_last,
    input wire logic [31:0] out_element
);
    `PL_ASSERT_IMP(a_count_max, i_clk, i_rst_n, out_valid, out_count <= 5'd16)
    `PL_ASSERT_IMP(a_nondump_zero, i_clk, i_rst_n, out_valid && out_status != 2'd0, out_last && out_element == 32'd0)
    `PL_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `PL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_element))
endmodule

bind positional_list_insert_delete_core pl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_req.valid), .in_ready(i_req.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready),
    .out_count(o_res.count), .out_status(o_res.status),
    .out_last(o_res.last), .out_element(o_res.element)
);
`default_nettype wire
